// ===== design/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst, expr, msg)

`define ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

// ===== design/hpt_pkg.sv =====
`default_nettype none

package hpt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 64;
   localparam int SUM_W         = 66;
   localparam int MAG_W         = 64;
   localparam int QUO_W         = 32;
   localparam int ROWS          = 4;
   localparam int COLS          = 4;
   localparam int LANES         = 3;
   localparam int IDX_W         = 4;

   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_POINT = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [IDX_W-1:0]          elem_index;
      logic signed [DATA_W-1:0]  elem_value;
      logic signed [DATA_W-1:0]  point_x;
      logic signed [DATA_W-1:0]  point_y;
      logic signed [DATA_W-1:0]  point_z;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  out_x;
      logic signed [DATA_W-1:0]  out_y;
      logic signed [DATA_W-1:0]  out_z;
      logic                      zero_divisor;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== design/hpt_if.sv =====
`default_nettype none

interface hpt_req_if;
   import hpt_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hpt_rsp_if;
   import hpt_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/homogeneous_point_transform.sv =====
// Homogeneous 4x4 point transform, signed fixed point with FRAC_BITS fraction bits.
// Load items (op = 0) write one matrix element and give no result; the matrix resets
// to identity and a load affects every point accepted after it. Point items (op = 1)
// give one result: rows 0..2 dotted with (x,y,z,1), each divided by row 3 dotted with
// (x,y,z,1), truncated toward zero and saturated; a zero divisor sets zero_divisor and
// zeros the coordinates. One item is taken every cycle while the output is not held.
// A point's result passes one multiply stage, two add stages, a magnitude stage,
// a range check stage, 32 stages of a restoring divider (one quotient bit each, three
// lanes sharing the divisor) and the output register. When the output is held, the
// whole pipeline holds.
`default_nettype none
`include "assert_macros.svh"

module homogeneous_point_transform #(
   parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hpt_req_if.sink     req_ch,
   hpt_rsp_if.source   rsp_ch
);
   import hpt_pkg::*;

   localparam int DIV_W  = MAG_W + FRAC_BITS;
   localparam int CMP_W  = MAG_W + QUO_W;
   localparam int HEAD_W = DIV_W - QUO_W;
   localparam int STAGES = QUO_W;

   logic out_v_ff;
   logic en;
   logic req_acc;
   assign en      = !out_v_ff || rsp_ch.ready;
   assign req_acc = req_ch.valid && en;

   // matrix
   logic signed [DATA_W-1:0] mat_ff [ROWS][COLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               mat_ff[r][c] <= (r == c) ? (DATA_W'(1) << FRAC_BITS) : '0;
            end
         end
      end else if (req_acc && req_ch.data.op == OP_LOAD) begin
         mat_ff[req_ch.data.elem_index[3:2]][req_ch.data.elem_index[1:0]] <=
            req_ch.data.elem_value;
      end
   end

   // stage 1: products
   logic signed [PROD_W-1:0] prod_in [ROWS][3];
   logic signed [PROD_W-1:0] prod_ff [ROWS][3];
   logic signed [PROD_W-1:0] cterm_in [ROWS];
   logic signed [PROD_W-1:0] cterm_ff [ROWS];
   logic v1_ff;

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         prod_in[r][0] = PROD_W'(req_ch.data.point_x) * PROD_W'(mat_ff[r][0]);
         prod_in[r][1] = PROD_W'(req_ch.data.point_y) * PROD_W'(mat_ff[r][1]);
         prod_in[r][2] = PROD_W'(req_ch.data.point_z) * PROD_W'(mat_ff[r][2]);
         cterm_in[r]   = PROD_W'(mat_ff[r][3]) <<< FRAC_BITS;
      end
   end

   // stages 2-4: sums, magnitudes
   logic signed [SUM_W-1:0] pa_ff [ROWS];
   logic signed [SUM_W-1:0] pb_ff [ROWS];
   logic signed [SUM_W-1:0] sum_ff [ROWS];
   logic [MAG_W-1:0]        mag_ff [ROWS];
   logic                    nneg_ff [ROWS];
   logic                    zd4_ff;
   logic                    v2_ff, v3_ff, v4_ff;

   // divider stages
   logic [MAG_W-1:0] rem_in  [STAGES+1][LANES];
   logic [MAG_W-1:0] rem_ff  [STAGES+1][LANES];
   logic [QUO_W-1:0] low_in  [STAGES+1][LANES];
   logic [QUO_W-1:0] low_ff  [STAGES+1][LANES];
   logic [QUO_W-1:0] quo_in  [STAGES+1][LANES];
   logic [QUO_W-1:0] quo_ff  [STAGES+1][LANES];
   logic             ovf_in  [STAGES+1][LANES];
   logic             ovf_ff  [STAGES+1][LANES];
   logic             neg_in  [STAGES+1][LANES];
   logic             neg_ff  [STAGES+1][LANES];
   logic [MAG_W-1:0] dmag_in [STAGES+1];
   logic [MAG_W-1:0] dmag_ff [STAGES+1];
   logic             zd_in   [STAGES+1];
   logic             zd_ff   [STAGES+1];
   logic             dv_in   [STAGES+1];
   logic             dv_ff   [STAGES+1];

   always_comb begin
      logic [DIV_W-1:0] dvd;
      logic [MAG_W:0]   t;
      logic             ge;
      dvd = '0;
      t   = '0;
      ge  = 1'b0;
      dmag_in[0] = mag_ff[3];
      zd_in[0]   = zd4_ff;
      dv_in[0]   = v4_ff;
      for (int l = 0; l < LANES; l++) begin
         dvd           = DIV_W'(mag_ff[l]) << FRAC_BITS;
         ovf_in[0][l]  = (CMP_W'(mag_ff[l]) << FRAC_BITS) >= (CMP_W'(mag_ff[3]) << QUO_W);
         rem_in[0][l]  = MAG_W'(dvd[DIV_W-1 -: HEAD_W]);
         low_in[0][l]  = dvd[QUO_W-1:0];
         quo_in[0][l]  = '0;
         neg_in[0][l]  = nneg_ff[l] ^ nneg_ff[3];
      end
      for (int k = 0; k < STAGES; k++) begin
         dmag_in[k+1] = dmag_ff[k];
         zd_in[k+1]   = zd_ff[k];
         dv_in[k+1]   = dv_ff[k];
         for (int l = 0; l < LANES; l++) begin
            t  = {rem_ff[k][l], low_ff[k][l][QUO_W-1]};
            ge = t >= {1'b0, dmag_ff[k]};
            rem_in[k+1][l] = ge ? MAG_W'(t - {1'b0, dmag_ff[k]}) : t[MAG_W-1:0];
            low_in[k+1][l] = low_ff[k][l] << 1;
            quo_in[k+1][l] = {quo_ff[k][l][QUO_W-2:0], ge};
            ovf_in[k+1][l] = ovf_ff[k][l];
            neg_in[k+1][l] = neg_ff[k][l];
         end
      end
   end

   // output
   rsp_item_type out_in, out_ff;
   logic [DATA_W-1:0] coord [LANES];

   always_comb begin
      logic [QUO_W-1:0] q;
      q = '0;
      for (int l = 0; l < LANES; l++) begin
         q = quo_ff[STAGES][l];
         if (zd_ff[STAGES]) begin
            coord[l] = '0;
         end else if (neg_ff[STAGES][l]) begin
            coord[l] = (ovf_ff[STAGES][l] || q > SAT_MIN) ? SAT_MIN : DATA_W'(0 - q);
         end else begin
            coord[l] = (ovf_ff[STAGES][l] || q[QUO_W-1]) ? SAT_MAX : q;
         end
      end
      out_in.out_x        = coord[0];
      out_in.out_y        = coord[1];
      out_in.out_z        = coord[2];
      out_in.zero_divisor = zd_ff[STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= STAGES; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v1_ff    <= req_acc && req_ch.data.op == OP_POINT;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         out_v_ff <= dv_ff[STAGES];
         for (int k = 0; k <= STAGES; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[r][j] <= prod_in[r][j];
            end
            cterm_ff[r] <= cterm_in[r];
            pa_ff[r]    <= SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]);
            pb_ff[r]    <= SUM_W'(prod_ff[r][2]) + SUM_W'(cterm_ff[r]);
            sum_ff[r]   <= pa_ff[r] + pb_ff[r];
            nneg_ff[r]  <= sum_ff[r][SUM_W-1];
            mag_ff[r]   <= sum_ff[r][SUM_W-1] ? MAG_W'(-sum_ff[r]) : MAG_W'(sum_ff[r]);
         end
         zd4_ff <= (sum_ff[3] == '0);
         for (int k = 0; k <= STAGES; k++) begin
            dmag_ff[k] <= dmag_in[k];
            zd_ff[k]   <= zd_in[k];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               low_ff[k][l] <= low_in[k][l];
               quo_ff[k][l] <= quo_in[k][l];
               ovf_ff[k][l] <= ovf_in[k][l];
               neg_ff[k][l] <= neg_in[k][l];
            end
         end
         out_ff <= out_in;
      end
   end

   assign req_ch.ready = en;
   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.data  = out_ff;

   `ASSERT_HOLDS(a_zero_div_coords, clock, reset, !(out_v_ff && out_ff.zero_divisor) || (out_ff.out_x == '0 && out_ff.out_y == '0 && out_ff.out_z == '0), "zero divisor with nonzero coordinates")
   `ASSERT_NEXT(a_load_no_item, clock, reset, req_acc && req_ch.data.op == OP_LOAD, !v1_ff, "load item entered the pipeline")
   `ASSERT_NEXT(a_point_enters, clock, reset, req_acc && req_ch.data.op == OP_POINT, v1_ff, "point item dropped at entry")
   `ASSERT_NEXT(a_stall_holds, clock, reset, out_v_ff && !rsp_ch.ready, out_v_ff && $stable(dv_ff[STAGES]), "pipeline advanced while stalled")

endmodule

`default_nettype wire

// ===== bench/homogeneous_point_transform_test.sv =====
`timescale 1ns / 100ps

module homogeneous_point_transform_test;
   import hpt_pkg::*;

   localparam int FB        = FRAC_BITS_DEF;
   localparam int WATCHDOG  = 5000;
   localparam int DRAIN     = 60;
   localparam logic signed [127:0] Q_MAX = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] Q_MIN = -128'sh8000_0000;
   localparam logic signed [31:0]  ONE   = 32'sh0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hpt_req_if req_ch ();
   hpt_rsp_if rsp_ch ();

   homogeneous_point_transform dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   logic signed [31:0] matrix [16];
   rsp_item_type       pending_points [$];
   int                 errors     = 0;
   int                 burst_left = 0;
   int                 hold_left  = 0;
   int                 idle_count = 0;
   int                 rx_phase   = 0;
   bit                 rx_stall   = 1'b0;

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.data   = '0;
      rsp_ch.ready  = 1'b0;
      for (int i = 0; i < 16; i++) begin
         matrix[i] = (i % 5 == 0) ? ONE : 32'sd0;
      end
   end

   function automatic rsp_item_type transform_point(logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
      rsp_item_type       res;
      logic signed [127:0] ex, ey, ez, m0, m1, m2, m3, w, q;
      logic signed [127:0] dot [4];
      ex = px;
      ey = py;
      ez = pz;
      for (int r = 0; r < 4; r++) begin
         m0 = matrix[r*4];
         m1 = matrix[r*4+1];
         m2 = matrix[r*4+2];
         m3 = matrix[r*4+3];
         dot[r] = ex * m0 + ey * m1 + ez * m2 + (m3 <<< FB);
      end
      w = dot[3];
      res = '0;
      if (w == 0) begin
         res.zero_divisor = 1'b1;
         return res;
      end
      for (int r = 0; r < 3; r++) begin
         q = (dot[r] <<< FB) / w;
         if (q > Q_MAX) q = Q_MAX;
         else if (q < Q_MIN) q = Q_MIN;
         case (r)
            0: res.out_x = q[31:0];
            1: res.out_y = q[31:0];
            default: res.out_z = q[31:0];
         endcase
      end
      return res;
   endfunction

   // track the matrix and expected results in acceptance order
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (req_ch.data.op == OP_LOAD) begin
            matrix[req_ch.data.elem_index] = req_ch.data.elem_value;
         end else begin
            pending_points.push_back(transform_point(req_ch.data.point_x,
                                                     req_ch.data.point_y,
                                                     req_ch.data.point_z));
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type exp_item;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h zd=%b", $time,
                     rsp_ch.data.out_x, rsp_ch.data.out_y, rsp_ch.data.out_z,
                     rsp_ch.data.zero_divisor);
            errors++;
         end else begin
            exp_item = pending_points.pop_front();
            if (rsp_ch.data.out_x !== exp_item.out_x) begin
               $display("%0t: out_x expected %h actual %h", $time,
                        exp_item.out_x, rsp_ch.data.out_x);
               errors++;
            end
            if (rsp_ch.data.out_y !== exp_item.out_y) begin
               $display("%0t: out_y expected %h actual %h", $time,
                        exp_item.out_y, rsp_ch.data.out_y);
               errors++;
            end
            if (rsp_ch.data.out_z !== exp_item.out_z) begin
               $display("%0t: out_z expected %h actual %h", $time,
                        exp_item.out_z, rsp_ch.data.out_z);
               errors++;
            end
            if (rsp_ch.data.zero_divisor !== exp_item.zero_divisor) begin
               $display("%0t: zero_divisor expected %b actual %b", $time,
                        exp_item.zero_divisor, rsp_ch.data.zero_divisor);
               errors++;
            end
         end
      end
   end

   // receiver: alternates free-running and stalling stretches, plus long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         if (rx_phase == 0) begin
            rx_phase = $urandom_range(8, 80);
            rx_stall = ($urandom_range(0, 2) != 0);
         end
         rx_phase = rx_phase - 1;
         rsp_ch.ready <= rx_stall ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG) begin
         $display("homogeneous_point_transform_test: errors");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   task automatic send_item(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic load_elem(input int idx, input logic [31:0] value);
      req_item_type it;
      it = '0;
      it.op         = OP_LOAD;
      it.elem_index = idx[3:0];
      it.elem_value = value;
      it.point_x    = $urandom;
      it.point_y    = $urandom;
      it.point_z    = $urandom;
      send_item(it);
   endtask

   task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz);
      req_item_type it;
      it = '0;
      it.op         = OP_POINT;
      it.elem_index = 4'($urandom);
      it.elem_value = $urandom;
      it.point_x    = px;
      it.point_y    = py;
      it.point_z    = pz;
      send_item(it);
   endtask

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] modest(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic test_identity();
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h0001_8000, 32'hFFFE_4000, 32'h0000_0001);
   endtask

   task automatic test_load_extremes();
      for (int i = 0; i < 16; i++) begin
         load_elem(i, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
      end
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
   endtask

   task automatic test_zero_divisor();
      for (int i = 12; i < 16; i++) load_elem(i, 32'h0);
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      load_elem(12, ONE);
      send_point(32'h0, 32'h1234_5678, 32'h8765_4321);
      send_point(32'h0000_0001, 32'h0, 32'h0);
   endtask

   task automatic test_saturation();
      for (int i = 0; i < 12; i++) load_elem(i, (i % 5 == 0) ? 32'h7FFF_0000 : 32'h0);
      load_elem(12, 32'h0);
      load_elem(15, 32'h0000_0001);
      send_point(32'h7FFF_0000, 32'hC000_0000, 32'h0100_0000);
      load_elem(15, 32'hFFFF_FFFF);
      send_point(32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
   endtask

   task automatic random_matrix();
      for (int i = 0; i < 12; i++) begin
         load_elem(i, ($urandom_range(0, 3) == 0) ? 32'h0 : modest(1 << 18));
      end
      load_elem(12, ($urandom_range(0, 1)) ? modest(1 << 10) : 32'h0);
      load_elem(13, ($urandom_range(0, 1)) ? modest(1 << 10) : 32'h0);
      load_elem(14, modest(1 << 12));
      load_elem(15, ($urandom_range(0, 7) == 0) ? 32'h0 : modest(1 << 18));
   endtask

   task automatic test_random(input int count);
      int sent;
      int n;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            random_matrix();
            n = $urandom_range(4, 30);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0) send_point(32'h0, 32'h0, 32'h0);
               else send_point(modest(1 << 24), modest(1 << 24), modest(1 << 24));
            end
            sent += n + 16;
         end else begin
            n = $urandom_range(4, 20);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 2) == 0) load_elem($urandom_range(0, 15), any_word());
               else send_point(any_word(), any_word(), any_word());
            end
            sent += n;
         end
      end
   endtask

   task automatic test_backpressure();
      random_matrix();
      hold_left = 300;
      for (int k = 0; k < 100; k++) begin
         send_point(modest(1 << 22), modest(1 << 22), modest(1 << 22));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity();
      test_load_extremes();
      test_zero_divisor();
      test_saturation();
      test_backpressure();
      test_random(1340);
      req_ch.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && pending_points.size() == 0) begin
         $display("homogeneous_point_transform_test: clean");
      end else begin
         $display("homogeneous_point_transform_test: errors");
      end
      $finish;
   end

endmodule
